// ----- rtl/cmmn_pkg.sv -----
// shared constants, codes and controller/datapath interface types for the column normalizer
package cmmn_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 64;
  localparam int FRAC_DEF  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 2'd1;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_INV  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FIT  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // result source selected when the output register loads
  localparam logic [1:0] SEL_PASS    = 2'd0;
  localparam logic [1:0] SEL_NOT_FIT = 2'd1;
  localparam logic [1:0] SEL_INV     = 2'd2;
  localparam logic [1:0] SEL_NORM    = 2'd3;

  localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic       take;
    logic       store;
    logic       fit_run;
    logic       fit_byp;
    logic       rd;
    logic       div_start;
    logic       mul;
    logic       adj;
    logic       put;
    logic       next;
    logic       clear;
    logic [1:0] sel;
  } cmmn_cmd_t;

  typedef struct packed {
    logic last;
    logic miss;
    logic emit_miss;
    logic emit_final;
    logic div_done;
    logic fitted;
    logic out_free;
  } cmmn_stat_t;

endpackage

// ----- rtl/column_min_max_normalizer_core.sv -----
// Min-max normalizer for one column of signed fixed-point samples (FRAC_BITS fraction bits).
// One request is taken at a time; sample_stall stays high until its work is done.
// Pass-through, bypass and unscaled inverse requests produce one result directly, scaled inverse
// requests multiply, then round and saturate, and forward requests that are not last are only stored.
// A forward request marked last adds a fit step and then emits every buffered sample:
// a missing sample skips the divider, a valid one is divided to FRAC_BITS fraction bits (Q16.16
// by default) by the divider that produces one quotient bit per cycle. Results wait in an
// output register, so a stalled output only holds the block while a new result is due.
// Configuration writes are always accepted and may be issued only while the block is idle.
module column_min_max_normalizer_core
  import cmmn_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     missing,
  input  logic                     last,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     value_missing,
  output logic                     end_of_run,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] fit_low,
  output logic signed [DATA_W-1:0] fit_high,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cmmn_cmd_t  cmd;
  cmmn_stat_t st;

  cmmn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .st           (st),
    .cmd          (cmd)
  );

  cmmn_dpath #(
    .DEPTH     (DEPTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .st            (st),
    .sample        (sample),
    .missing       (missing),
    .last          (last),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .value         (value),
    .value_missing (value_missing),
    .end_of_run    (end_of_run),
    .status        (status),
    .fit_low       (fit_low),
    .fit_high      (fit_high)
  );

endmodule

// ----- rtl/cmmn_div.sv -----
// restoring divider, one quotient bit per cycle, for num <= den
module cmmn_div
  import cmmn_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DATA_W-1:0]   num,
  input  logic [DATA_W-1:0]   den,
  output logic                done,
  output logic [FRAC_BITS:0]  quot
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   rem;
  logic              ge;
  logic [DATA_W-1:0] diff;

  // rem stays below twice den, so the difference fits in DATA_W bits
  assign ge   = rem >= {1'b0, den};
  assign diff = rem[DATA_W-1:0] - den;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      quot <= '0;
    end else if (cnt != '0) begin
      rem  <= ge ? {diff, 1'b0} : {rem[DATA_W-1:0], 1'b0};
      quot <= {quot[FRAC_BITS-1:0], ge};
    end
  end

endmodule

// ----- rtl/cmmn_dpath.sv -----
// sample buffer, running extremes, fit registers, inverse multiplier and output register
module cmmn_dpath
  import cmmn_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmmn_cmd_t                cmd,
  output cmmn_stat_t               st,
  input  logic signed [DATA_W-1:0] sample,
  input  logic                     missing,
  input  logic                     last,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     value_missing,
  output logic                     end_of_run,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] fit_low,
  output logic signed [DATA_W-1:0] fit_high
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * DATA_W + 1;
  localparam int SUM_W = PW + 1;
  localparam logic signed [DATA_W:0] ONE_FX = (DATA_W + 1)'(1) << FRAC_BITS;

  logic [DATA_W:0] store_mem [DEPTH];
  logic [DATA_W:0] rd_word;

  logic signed [DATA_W-1:0] x_q;
  logic                     miss_q;
  logic                     last_q;

  logic [CW-1:0]            fill;
  logic [CW-1:0]            emit_idx;
  logic                     have_valid;
  logic                     overflowed;
  logic                     fitted;
  logic signed [DATA_W-1:0] run_lo;
  logic signed [DATA_W-1:0] run_hi;
  logic signed [DATA_W-1:0] stored_lo;
  logic signed [DATA_W-1:0] stored_hi;
  logic signed [DATA_W:0]   span;

  logic signed [DATA_W-1:0] fit_lo;
  logic signed [DATA_W-1:0] fit_hi;
  logic signed [DATA_W:0]   fit_diff;
  logic signed [DATA_W:0]   fit_span;

  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     inv_shift;
  logic                     inv_rnd;
  logic signed [SUM_W-1:0]  inv_sum;
  logic signed [DATA_W-1:0] inv_q;

  logic signed [DATA_W-1:0] rd_v;
  logic signed [DATA_W:0]   rd_diff;
  logic [DATA_W-1:0]        div_num;
  logic                     div_done;
  logic [FRAC_BITS:0]       quot;

  logic full;
  logic emit_final;
  logic out_free;

  assign full       = (fill == CW'(DEPTH));
  assign emit_final = (emit_idx == fill - CW'(1));
  assign out_free   = !result_valid || !result_stall;

  assign st.last       = last_q;
  assign st.miss       = miss_q;
  assign st.emit_miss  = rd_word[DATA_W];
  assign st.emit_final = emit_final;
  assign st.div_done   = div_done;
  assign st.fitted     = fitted;
  assign st.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_q    <= sample;
      miss_q <= missing;
      last_q <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      store_mem[fill[AW-1:0]] <= {miss_q, x_q};
    end
    if (cmd.rd) begin
      rd_word <= store_mem[emit_idx[AW-1:0]];
    end
  end

  // fit from the running extremes, falling back to 0 and 1.0
  always_comb begin
    fit_lo   = have_valid ? run_lo : '0;
    fit_hi   = have_valid ? run_hi : ONE_FX[DATA_W-1:0];
    fit_diff = {fit_hi[DATA_W-1], fit_hi} - {fit_lo[DATA_W-1], fit_lo};
    fit_span = (fit_diff == '0) ? ONE_FX : fit_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      emit_idx   <= '0;
      have_valid <= 1'b0;
      overflowed <= 1'b0;
      fitted     <= 1'b0;
      run_lo     <= S_MAX;
      run_hi     <= S_MIN;
      stored_lo  <= '0;
      stored_hi  <= '0;
      span       <= ONE_FX;
    end else begin
      if (cmd.store) begin
        if (full) begin
          overflowed <= 1'b1;
        end else begin
          fill <= fill + CW'(1);
          if (!miss_q) begin
            have_valid <= 1'b1;
            if (x_q < run_lo) run_lo <= x_q;
            if (x_q > run_hi) run_hi <= x_q;
          end
        end
      end
      if (cmd.fit_run) begin
        stored_lo <= fit_lo;
        stored_hi <= fit_hi;
        span      <= fit_span;
        fitted    <= 1'b1;
      end
      if (cmd.fit_byp) begin
        stored_lo <= '0;
        stored_hi <= ONE_FX[DATA_W-1:0];
        span      <= ONE_FX;
        fitted    <= 1'b1;
      end
      if (cmd.next) begin
        emit_idx <= emit_idx + CW'(1);
      end
      if (cmd.clear) begin
        fill       <= '0;
        emit_idx   <= '0;
        have_valid <= 1'b0;
        overflowed <= 1'b0;
        run_lo     <= S_MAX;
        run_hi     <= S_MIN;
      end
    end
  end

  // inverse: x * span, truncated toward zero, plus min, saturated
  always_comb begin
    inv_shift = prod >>> FRAC_BITS;
    inv_rnd   = prod[PW-1] & (|prod[FRAC_BITS-1:0]);
    inv_sum   = SUM_W'(inv_shift) + SUM_W'(stored_lo) + {{(SUM_W-1){1'b0}}, inv_rnd};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PW'(x_q) * PW'(span);
    end
    if (cmd.adj) begin
      if (inv_sum > SUM_W'(S_MAX)) begin
        inv_q <= S_MAX;
      end else if (inv_sum < SUM_W'(S_MIN)) begin
        inv_q <= S_MIN;
      end else begin
        inv_q <= inv_sum[DATA_W-1:0];
      end
    end
  end

  // buffered valid samples never sit below the fitted min
  assign rd_v    = rd_word[DATA_W-1:0];
  assign rd_diff = {rd_v[DATA_W-1], rd_v} - {stored_lo[DATA_W-1], stored_lo};
  assign div_num = rd_diff[DATA_W] ? '0 : rd_diff[DATA_W-1:0];

  // num <= span, so the quotient never exceeds 1.0 and needs no clamp
  cmmn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (span[DATA_W-1:0]),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.put) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      fit_low  <= stored_lo;
      fit_high <= stored_hi;
      case (cmd.sel)
        SEL_PASS: begin
          value         <= x_q;
          value_missing <= miss_q;
          end_of_run    <= last_q;
          status        <= ST_OK;
        end
        SEL_NOT_FIT: begin
          value         <= '0;
          value_missing <= 1'b0;
          end_of_run    <= last_q;
          status        <= ST_NOT_FIT;
        end
        SEL_INV: begin
          value         <= inv_q;
          value_missing <= 1'b0;
          end_of_run    <= last_q;
          status        <= ST_OK;
        end
        default: begin
          value         <= rd_word[DATA_W] ? rd_v : DATA_W'(quot);
          value_missing <= rd_word[DATA_W];
          end_of_run    <= emit_final;
          status        <= overflowed ? ST_OVERFLOW : ST_OK;
        end
      endcase
    end
  end

endmodule

// ----- rtl/cmmn_ctrl.sv -----
// configuration registers and sequencing state machine
module cmmn_ctrl
  import cmmn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmmn_stat_t            st,
  output cmmn_cmd_t             cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_ADJ  = 4'd2;
  localparam logic [3:0] S_PUT1 = 4'd3;
  localparam logic [3:0] S_FIT  = 4'd4;
  localparam logic [3:0] S_READ = 4'd5;
  localparam logic [3:0] S_LOAD = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_PUTE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] sel_q;
  logic [1:0] sel_next;
  logic [1:0] mode;
  logic       bypass;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_FWD;
      bypass <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:   mode   <= cfg_data;
        REG_BYPASS: bypass <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    sel_next   = sel_q;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (mode)
          MODE_INV: begin
            if (!st.fitted) begin
              sel_next   = SEL_NOT_FIT;
              state_next = S_PUT1;
            end else if (bypass || st.miss) begin
              sel_next   = SEL_PASS;
              state_next = S_PUT1;
            end else begin
              cmd.mul    = 1'b1;
              state_next = S_ADJ;
            end
          end
          MODE_FWD: begin
            if (bypass) begin
              cmd.fit_byp = st.last;
              sel_next    = SEL_PASS;
              state_next  = S_PUT1;
            end else begin
              cmd.store  = 1'b1;
              state_next = st.last ? S_FIT : S_IDLE;
            end
          end
          default: begin
            sel_next   = SEL_PASS;
            state_next = S_PUT1;
          end
        endcase
      end
      S_ADJ: begin
        cmd.adj    = 1'b1;
        sel_next   = SEL_INV;
        state_next = S_PUT1;
      end
      S_PUT1: begin
        cmd.sel = sel_q;
        if (st.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIT: begin
        cmd.fit_run = 1'b1;
        state_next  = S_READ;
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // missing entries skip the divider
        if (st.emit_miss) begin
          state_next = S_PUTE;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_PUTE;
        end
      end
      S_PUTE: begin
        cmd.sel = SEL_NORM;
        if (st.out_free) begin
          cmd.put = 1'b1;
          if (st.emit_final) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel_q <= SEL_PASS;
    end else begin
      state <= state_next;
      sel_q <= sel_next;
    end
  end

endmodule

// ----- rtl/cmmn_checker.sv -----
// port-level checks for the column normalizer, bound to the top level
module cmmn_checker
  import cmmn_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     sample_valid,
  input logic                     sample_stall,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic signed [DATA_W-1:0] value,
  input logic                     value_missing,
  input logic [1:0]               status,
  input logic signed [DATA_W-1:0] fit_low,
  input logic signed [DATA_W-1:0] fit_high
);

  // one request in flight: the port closes right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("request accepted while previous one still in work");

  a_not_fit_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_NOT_FIT |-> value == '0 && !value_missing)
    else $error("not-fitted result carries data");

  a_fit_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> fit_low <= fit_high)
    else $error("fitted min above fitted max");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind column_min_max_normalizer_core cmmn_checker u_cmmn_checker (.*);
